@@ rtl/step_sequence_text_parser_defines.svh @@
// Assertion macros shared by the step sequence text parser.
`ifndef STEP_SEQUENCE_TEXT_PARSER_DEFINES_SVH
`define STEP_SEQUENCE_TEXT_PARSER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define SSP_ASSERT_NOW(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("ssp check failed");

// Check that a condition implies another in the following cycle.
`define SSP_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("ssp check failed");

`endif

@@ rtl/ssp_pkg.sv @@
package ssp_pkg;

  localparam int DEF_OUTPUT_SLOTS = 16;

  // Characters of interest
  localparam logic [7:0] CHAR_OPEN  = 8'h5B;
  localparam logic [7:0] CHAR_CLOSE = 8'h5D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Result kinds
  localparam logic [1:0] KIND_CHANNEL = 2'd0;
  localparam logic [1:0] KIND_TIMING  = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  typedef enum logic [3:0] {
    PH_WAIT_OUTER = 4'd0,
    PH_BETWEEN    = 4'd1,
    PH_OPENER     = 4'd2,
    PH_OUT_FRESH  = 4'd3,
    PH_OUT_NUM    = 4'd4,
    PH_SKIP_SEP   = 4'd5,
    PH_OFFSET     = 4'd6,
    PH_DURATION   = 4'd7,
    PH_REPS       = 4'd8,
    PH_ERROR      = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    NUM_MORE = 2'd0,
    NUM_DONE = 2'd1,
    NUM_BAD  = 2'd2
  } num_status_t;

  // Number being read
  typedef struct packed {
    logic [31:0] acc;
    logic        neg;
    logic        digit_seen;
    logic        sign_seen;
  } num_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic [7:0]         channel;
    logic [3:0]         channel_slot;
    logic signed [31:0] step_offset;
    logic signed [31:0] step_duration;
    logic signed [31:0] step_repetitions;
    logic [4:0]         channel_count;
  } out_item_t;

endpackage

@@ rtl/ssp_number.sv @@
module ssp_number (
  input  logic [7:0]           text_char,
  input  ssp_pkg::num_t        num,
  output ssp_pkg::num_t        num_fed,
  output ssp_pkg::num_status_t status,
  output logic [31:0]          value
);
  import ssp_pkg::*;

  logic        is_digit;
  logic        is_space;
  logic        is_sign;
  logic [35:0] acc_wide;
  logic [35:0] acc_ten;

  assign is_digit = (text_char >= CHAR_ZERO) && (text_char <= CHAR_NINE);
  assign is_space = (text_char == CHAR_SPACE) ||
                    ((text_char >= CHAR_TAB) && (text_char <= CHAR_CR));
  assign is_sign  = (text_char == CHAR_PLUS) || (text_char == CHAR_MINUS);

  // Multiply by ten as two shifts and add the digit
  assign acc_wide = {4'b0, num.acc};
  assign acc_ten  = (acc_wide << 3) + (acc_wide << 1) +
                    {32'b0, 4'(text_char - CHAR_ZERO)};

  // Saturated two's complement value of the number read so far
  always_comb begin
    if (num.neg) begin
      value = 32'd0 - num.acc;
    end else if (num.acc[31]) begin
      value = POS_MAX;
    end else begin
      value = num.acc;
    end
  end

  // Feed one character into the number
  always_comb begin
    num_fed = num;
    status  = NUM_BAD;
    if (is_digit) begin
      num_fed.acc        = (acc_ten > {4'b0, MAG_CAP}) ? MAG_CAP : acc_ten[31:0];
      num_fed.digit_seen = 1'b1;
      status             = NUM_MORE;
    end else if (num.digit_seen) begin
      status = NUM_DONE;
    end else if (!num.sign_seen && is_space) begin
      status = NUM_MORE;
    end else if (!num.sign_seen && is_sign) begin
      num_fed.sign_seen = 1'b1;
      num_fed.neg       = (text_char == CHAR_MINUS);
      status            = NUM_MORE;
    end
  end

endmodule

@@ rtl/ssp_parser.sv @@
module ssp_parser #(
  parameter int OUTPUT_SLOTS = ssp_pkg::DEF_OUTPUT_SLOTS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  ssp_pkg::in_item_t   item,
  output logic                res_valid,
  output ssp_pkg::out_item_t  res
);
  import ssp_pkg::*;

  localparam int KW = $clog2(OUTPUT_SLOTS + 1);

  phase_t      phase, phase_next;
  num_t        num, num_next, num_fed;
  num_status_t status;
  logic [31:0] value;
  logic [KW-1:0] kept, kept_next;
  logic [31:0] held_offset, held_offset_next;
  logic [31:0] held_duration, held_duration_next;
  logic [KW+4:0] kept_ext;
  logic        err;

  ssp_number u_number (
    .text_char (item.text_char),
    .num       (num),
    .num_fed   (num_fed),
    .status    (status),
    .value     (value)
  );

  assign kept_ext = {5'b0, kept};

  // Hold parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT_OUTER;
      num           <= '0;
      kept          <= '0;
      held_offset   <= '0;
      held_duration <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      num           <= num_next;
      kept          <= kept_next;
      held_offset   <= held_offset_next;
      held_duration <= held_duration_next;
    end
  end

  // Advance the phase and build the result for one character
  always_comb begin
    phase_next         = phase;
    num_next           = num;
    kept_next          = kept;
    held_offset_next   = held_offset;
    held_duration_next = held_duration;
    res_valid          = 1'b0;
    res                = '0;
    err                = 1'b0;
    if (item.end_of_text) begin
      phase_next = PH_WAIT_OUTER;
      num_next   = '0;
      if (phase == PH_WAIT_OUTER || phase == PH_BETWEEN) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_END;
      end else if (phase != PH_ERROR) begin
        res_valid       = 1'b1;
        res.result_kind = KIND_ERROR;
      end
    end else begin
      case (phase)
        PH_WAIT_OUTER: begin
          if (item.text_char == CHAR_OPEN) phase_next = PH_BETWEEN;
        end
        PH_BETWEEN: begin
          if (item.text_char == CHAR_OPEN) phase_next = PH_OPENER;
        end
        PH_OPENER: begin
          kept_next  = '0;
          num_next   = '0;
          phase_next = PH_OUT_FRESH;
        end
        PH_OUT_FRESH, PH_OUT_NUM: begin
          if (phase == PH_OUT_FRESH && item.text_char == CHAR_CLOSE) begin
            phase_next = PH_SKIP_SEP;
          end else begin
            phase_next = PH_OUT_NUM;
            case (status)
              NUM_MORE: num_next = num_fed;
              NUM_DONE: begin
                num_next   = '0;
                phase_next = (item.text_char == CHAR_CLOSE) ? PH_SKIP_SEP : PH_OUT_FRESH;
                // Drop channels beyond the slot count
                if (kept < KW'(OUTPUT_SLOTS)) begin
                  res_valid        = 1'b1;
                  res.result_kind  = KIND_CHANNEL;
                  res.channel      = value[7:0];
                  res.channel_slot = kept_ext[3:0];
                  kept_next        = kept + KW'(1);
                end
              end
              default: err = 1'b1;
            endcase
          end
        end
        PH_SKIP_SEP: begin
          num_next   = '0;
          phase_next = PH_OFFSET;
        end
        PH_OFFSET, PH_DURATION, PH_REPS: begin
          case (status)
            NUM_MORE: num_next = num_fed;
            NUM_DONE: begin
              num_next = '0;
              if (phase == PH_OFFSET) begin
                held_offset_next = value;
                phase_next       = PH_DURATION;
              end else if (phase == PH_DURATION) begin
                held_duration_next = value;
                phase_next         = PH_REPS;
              end else begin
                phase_next           = PH_BETWEEN;
                res_valid            = 1'b1;
                res.result_kind      = KIND_TIMING;
                res.step_offset      = held_offset;
                res.step_duration    = held_duration;
                res.step_repetitions = value;
                res.channel_count    = kept_ext[4:0];
              end
            end
            default: err = 1'b1;
          endcase
        end
        default: phase_next = PH_ERROR;
      endcase
      // Empty number: report and ignore the rest of the text
      if (err) begin
        num_next        = '0;
        phase_next      = PH_ERROR;
        res_valid       = 1'b1;
        res.result_kind = KIND_ERROR;
      end
    end
  end

endmodule

@@ rtl/step_sequence_text_parser.sv @@
// Channel | Handshake            | Payload
// in      | in_valid / in_ready  | in_data   (text_char, end_of_text)
// out     | out_valid / out_ready| out_data  (kind, channel, slot, timing, count)
//
// One character is taken every cycle while in_ready is high; each gives at most one result.
// A character passes through an input register, then the phase and number
// update into the result register, with a multiply-by-ten add as the longest path.
// Synchronous reset returns the parser to waiting for the outer list.
// A stalled result holds one further character in the input register,
// after which in_ready drops until the result is taken.
`include "step_sequence_text_parser_defines.svh"

module step_sequence_text_parser #(
  parameter int OUTPUT_SLOTS = ssp_pkg::DEF_OUTPUT_SLOTS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ssp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ssp_pkg::out_item_t out_data
);
  import ssp_pkg::*;

  logic      in_full;
  in_item_t  in_q;
  logic      adv;
  logic      res_valid;
  out_item_t res;

  assign adv      = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || adv;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
    if (in_valid && in_ready) begin
      in_q <= in_data;
    end
  end

  ssp_parser #(
    .OUTPUT_SLOTS (OUTPUT_SLOTS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (adv),
    .item      (in_q),
    .res_valid (res_valid),
    .res       (res)
  );

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= adv && res_valid;
    end
    if (adv && res_valid) begin
      out_data <= res;
    end
  end

  `SSP_ASSERT_NOW(a_chan_no_timing, out_valid && out_data.result_kind == KIND_CHANNEL, out_data.step_offset == 0 && out_data.channel_count == 0)
  `SSP_ASSERT_NOW(a_full_blocks, in_full && out_valid && !out_ready, !in_ready)
  `SSP_ASSERT_NEXT(a_eot_result, adv && in_q.end_of_text, !out_valid || out_data.result_kind == KIND_END || out_data.result_kind == KIND_ERROR)

endmodule
